>>> rtl/stri_pkg.sv
package stri_pkg;

    localparam int PIX_W  = 20;   // unsigned Q12.8 pixel quantities
    localparam int CD_W   = 21;   // centred coordinate, signed Q.8
    localparam int TR_W   = 32;   // translation, signed Q16.16
    localparam int OUT_W  = 32;   // results, signed Q.F
    localparam int NUM_W  = 51;   // magnitude of translation * focal
    localparam int DEN_W  = 41;   // magnitude of the disparity denominator
    localparam int PROD_W = 52;   // magnitude of |z| * |centred coordinate|
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FU_L = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FV_L = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CU_L = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CV_L = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FU_R = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CU_R = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TU_R = 3'd6;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic [OUT_W-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] LIM_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [PIX_W-1:0] fu_l;
        logic [PIX_W-1:0] fv_l;
        logic [PIX_W-1:0] cu_l;
        logic [PIX_W-1:0] cv_l;
        logic [PIX_W-1:0] fu_r;
        logic [PIX_W-1:0] cu_r;
        logic [TR_W-1:0]  tu_r;
    } cfg_t;

    // travels with an item through the depth divider
    typedef struct packed {
        logic            zero;
        logic            neg;
        logic [CD_W-1:0] du_l;
        logic [CD_W-1:0] dv_l;
    } zside_t;

    // travels with an item through the height divider
    typedef struct packed {
        logic             zero;
        logic             sat;
        logic             yneg;
        logic [OUT_W-1:0] zval;
    } yside_t;

endpackage

>>> rtl/stri_div.sv
module stri_div
    import stri_pkg::*;
#(
    parameter int NW = 52,
    parameter int DW = 20,
    parameter int QW = 32,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic          over,
    output logic [SW-1:0] side_out
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic          v_reg [0:QW];
    logic [W-1:0]  r_reg [0:QW];
    logic [DW-1:0] d_reg [0:QW];
    logic [QW-1:0] q_reg [0:QW];
    logic          o_reg [0:QW];
    logic [SW-1:0] s_reg [0:QW];

    // entry stage: flag quotients that do not fit in QW bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= W'(dividend);
            d_reg[0] <= divisor;
            q_reg[0] <= '0;
            o_reg[0] <= W'(dividend) >= (W'(divisor) << QW);
            s_reg[0] <= side_in;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int K = QW - 1 - i;
        logic [W:0] diff;
        logic       qbit;

        assign diff = {1'b0, r_reg[i]} - {1'b0, W'(d_reg[i]) << K};
        assign qbit = !diff[W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1] <= qbit ? diff[W-1:0] : r_reg[i];
                d_reg[i+1] <= d_reg[i];
                q_reg[i+1] <= {q_reg[i][QW-2:0], qbit};
                o_reg[i+1] <= o_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quot      = q_reg[QW];
    assign over      = o_reg[QW];
    assign side_out  = s_reg[QW];

endmodule

>>> rtl/stri_front.sv
module stri_front
    import stri_pkg::*;
#(
    parameter int SHIFT = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    input  logic [PIX_W-1:0]         u_left,
    input  logic [PIX_W-1:0]         v_left,
    input  logic [PIX_W-1:0]         u_right,
    output logic                     out_valid,
    output logic [NUM_W+SHIFT-1:0]   dividend,
    output logic [DEN_W-1:0]         divisor,
    output zside_t                   side
);

    localparam int NW = NUM_W + SHIFT;

    // stage 1: centre the coordinates, form the numerator
    logic                   v1_reg;
    logic signed [CD_W-1:0] du_l1_reg;
    logic signed [CD_W-1:0] dv_l1_reg;
    logic signed [CD_W-1:0] du_r1_reg;
    logic signed [52:0]     num1_reg;
    logic                   fz1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            du_l1_reg <= $signed({1'b0, u_left}) - $signed({1'b0, cfg.cu_l});
            dv_l1_reg <= $signed({1'b0, v_left}) - $signed({1'b0, cfg.cv_l});
            du_r1_reg <= $signed({1'b0, u_right}) - $signed({1'b0, cfg.cu_r});
            num1_reg  <= $signed(cfg.tu_r) * $signed({1'b0, cfg.fu_l});
            fz1_reg   <= (cfg.fu_l == '0) || (cfg.fv_l == '0);
        end
    end

    // stage 2: the two focal-weighted disparity products
    logic                   v2_reg;
    logic signed [41:0]     p1_reg;
    logic signed [41:0]     p2_reg;
    logic [NUM_W-1:0]       nmag2_reg;
    logic                   nneg2_reg;
    logic                   nnz2_reg;
    logic [CD_W-1:0]        du_l2_reg;
    logic [CD_W-1:0]        dv_l2_reg;
    logic                   fz2_reg;
    logic [52:0]            num_neg;

    assign num_neg = 53'd0 - num1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= du_r1_reg * $signed({1'b0, cfg.fu_l});
            p2_reg    <= du_l1_reg * $signed({1'b0, cfg.fu_r});
            nmag2_reg <= num1_reg[52] ? num_neg[NUM_W-1:0] : num1_reg[NUM_W-1:0];
            nneg2_reg <= num1_reg[52];
            nnz2_reg  <= num1_reg != '0;
            du_l2_reg <= du_l1_reg;
            dv_l2_reg <= dv_l1_reg;
            fz2_reg   <= fz1_reg;
        end
    end

    // stage 3: denominator, its magnitude and the quotient sign
    logic [42:0] den;
    logic [42:0] den_neg;
    logic        v3_reg;
    logic [NW-1:0]    dividend_reg;
    logic [DEN_W-1:0] divisor_reg;
    zside_t           side_reg;

    assign den     = {p1_reg[41], p1_reg} - {p2_reg[41], p2_reg};
    assign den_neg = 43'd0 - den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dividend_reg  <= NW'(nmag2_reg) << SHIFT;
            divisor_reg   <= den[42] ? den_neg[DEN_W-1:0] : den[DEN_W-1:0];
            side_reg.zero <= fz2_reg || (den == '0);
            side_reg.neg  <= (nneg2_reg != den[42]) && nnz2_reg;
            side_reg.du_l <= du_l2_reg;
            side_reg.dv_l <= dv_l2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign dividend  = dividend_reg;
    assign divisor   = divisor_reg;
    assign side      = side_reg;

endmodule

>>> rtl/stereo_triangulation.sv
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     u_left, v_left, u_right
// out       output     out_valid / out_stall   point_x, point_y, point_z, status
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One item per cycle unless a result stalls. 3 front stages, a 33-stage depth
// divider (one quotient bit per stage), 2 scaling stages, a 33-stage divider
// pair for height and lateral position, and the output register.
// Reset clears all valid bits and loads the default calibration.
// A stalled result freezes the whole pipeline; in_stall follows at once.
module stereo_triangulation
    import stri_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_W-1:0]       u_left,
    input  logic [PIX_W-1:0]       v_left,
    input  logic [PIX_W-1:0]       u_right,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic signed [OUT_W-1:0] point_z,
    output logic [1:0]             status
);

    localparam int ZSH = OUT_FRAC_BITS - 8;
    localparam int ZNW = NUM_W + ZSH;

    cfg_t cfg_reg;
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fu_l <= 20'd128000;
            cfg_reg.fv_l <= 20'd128000;
            cfg_reg.cu_l <= 20'd81920;
            cfg_reg.cv_l <= 20'd61440;
            cfg_reg.fu_r <= 20'd128000;
            cfg_reg.cu_r <= 20'd81920;
            cfg_reg.tu_r <= 32'hFF06_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FU_L: cfg_reg.fu_l <= cfg_data[PIX_W-1:0];
                CFG_FV_L: cfg_reg.fv_l <= cfg_data[PIX_W-1:0];
                CFG_CU_L: cfg_reg.cu_l <= cfg_data[PIX_W-1:0];
                CFG_CV_L: cfg_reg.cv_l <= cfg_data[PIX_W-1:0];
                CFG_FU_R: cfg_reg.fu_r <= cfg_data[PIX_W-1:0];
                CFG_CU_R: cfg_reg.cu_r <= cfg_data[PIX_W-1:0];
                CFG_TU_R: cfg_reg.tu_r <= cfg_data;
                default:  ;
            endcase
        end
    end

    // front end
    logic             f_valid;
    logic [ZNW-1:0]   f_dividend;
    logic [DEN_W-1:0] f_divisor;
    zside_t           f_side;

    stri_front #(.SHIFT(ZSH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .u_left    (u_left),
        .v_left    (v_left),
        .u_right   (u_right),
        .out_valid (f_valid),
        .dividend  (f_dividend),
        .divisor   (f_divisor),
        .side      (f_side)
    );

    // depth divider
    logic             zd_valid;
    logic [OUT_W-1:0] zd_quot;
    logic             zd_over;
    zside_t           zd_side;

    stri_div #(.NW(ZNW), .DW(DEN_W), .QW(OUT_W), .SW($bits(zside_t))) u_zdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f_valid),
        .dividend  (f_dividend),
        .divisor   (f_divisor),
        .side_in   (f_side),
        .out_valid (zd_valid),
        .quot      (zd_quot),
        .over      (zd_over),
        .side_out  (zd_side)
    );

    // clamp depth, take magnitudes of the centred coordinates
    logic [OUT_W-1:0] z_lim;
    logic             z_over;
    logic [OUT_W-1:0] z_mag;
    logic             z_nz;
    logic [CD_W-1:0]  du_neg;
    logic [CD_W-1:0]  dv_neg;

    assign z_lim  = zd_side.neg ? LIM_NEG : LIM_POS;
    assign z_over = zd_over || (zd_quot > z_lim);
    assign z_mag  = z_over ? z_lim : zd_quot;
    assign z_nz   = z_mag != '0;
    assign du_neg = CD_W'(0) - zd_side.du_l;
    assign dv_neg = CD_W'(0) - zd_side.dv_l;

    logic              c_valid_reg;
    logic [OUT_W-1:0]  zm_c_reg;
    logic [OUT_W-1:0]  zv_c_reg;
    logic [PIX_W-1:0]  dum_c_reg;
    logic [PIX_W-1:0]  dvm_c_reg;
    logic              xneg_c_reg;
    logic              yneg_c_reg;
    logic              zero_c_reg;
    logic              sat_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= zd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zm_c_reg   <= z_mag;
            zv_c_reg   <= zd_side.neg ? OUT_W'(0) - z_mag : z_mag;
            dum_c_reg  <= zd_side.du_l[CD_W-1] ? du_neg[PIX_W-1:0] : zd_side.du_l[PIX_W-1:0];
            dvm_c_reg  <= zd_side.dv_l[CD_W-1] ? dv_neg[PIX_W-1:0] : zd_side.dv_l[PIX_W-1:0];
            xneg_c_reg <= ((zd_side.neg && z_nz) != zd_side.du_l[CD_W-1]) && z_nz
                          && (zd_side.du_l != '0);
            yneg_c_reg <= ((zd_side.neg && z_nz) != zd_side.dv_l[CD_W-1]) && z_nz
                          && (zd_side.dv_l != '0);
            zero_c_reg <= zd_side.zero;
            sat_c_reg  <= z_over;
        end
    end

    // scale depth by the centred coordinates
    logic              m_valid_reg;
    logic [PROD_W-1:0] px_m_reg;
    logic [PROD_W-1:0] py_m_reg;
    logic              xneg_m_reg;
    yside_t            yside_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_m_reg         <= zm_c_reg * dum_c_reg;
            py_m_reg         <= zm_c_reg * dvm_c_reg;
            xneg_m_reg       <= xneg_c_reg;
            yside_m_reg.zero <= zero_c_reg;
            yside_m_reg.sat  <= sat_c_reg;
            yside_m_reg.yneg <= yneg_c_reg;
            yside_m_reg.zval <= zv_c_reg;
        end
    end

    // lateral and height dividers run side by side
    logic             xd_valid;
    logic [OUT_W-1:0] xd_quot;
    logic             xd_over;
    logic             xd_neg;
    logic             yd_valid;
    logic [OUT_W-1:0] yd_quot;
    logic             yd_over;
    yside_t           yd_side;

    stri_div #(.NW(PROD_W), .DW(PIX_W), .QW(OUT_W), .SW(1)) u_xdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m_valid_reg),
        .dividend  (px_m_reg),
        .divisor   (cfg_reg.fu_l),
        .side_in   (xneg_m_reg),
        .out_valid (xd_valid),
        .quot      (xd_quot),
        .over      (xd_over),
        .side_out  (xd_neg)
    );

    stri_div #(.NW(PROD_W), .DW(PIX_W), .QW(OUT_W), .SW($bits(yside_t))) u_ydiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m_valid_reg),
        .dividend  (py_m_reg),
        .divisor   (cfg_reg.fv_l),
        .side_in   (yside_m_reg),
        .out_valid (yd_valid),
        .quot      (yd_quot),
        .over      (yd_over),
        .side_out  (yd_side)
    );

    // clamp, sign and register the result
    logic [OUT_W-1:0] x_lim;
    logic [OUT_W-1:0] y_lim;
    logic             x_over;
    logic             y_over;
    logic [OUT_W-1:0] x_mag;
    logic [OUT_W-1:0] y_mag;

    assign x_lim  = xd_neg ? LIM_NEG : LIM_POS;
    assign y_lim  = yd_side.yneg ? LIM_NEG : LIM_POS;
    assign x_over = xd_over || (xd_quot > x_lim);
    assign y_over = yd_over || (yd_quot > y_lim);
    assign x_mag  = x_over ? x_lim : xd_quot;
    assign y_mag  = y_over ? y_lim : yd_quot;

    logic [OUT_W-1:0] px_reg;
    logic [OUT_W-1:0] py_reg;
    logic [OUT_W-1:0] pz_reg;
    logic [1:0]       status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= yd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (yd_side.zero)
            begin
                px_reg     <= '0;
                py_reg     <= '0;
                pz_reg     <= '0;
                status_reg <= STATUS_ZERO;
            end
            else
            begin
                px_reg     <= xd_neg ? OUT_W'(0) - x_mag : x_mag;
                py_reg     <= yd_side.yneg ? OUT_W'(0) - y_mag : y_mag;
                pz_reg     <= yd_side.zval;
                status_reg <= (yd_side.sat || x_over || y_over) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign point_z   = pz_reg;
    assign status    = status_reg;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        xd_valid == yd_valid)
        else $error("lateral and height dividers out of step");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_ZERO) |->
            (point_x == '0 && point_y == '0 && point_z == '0))
        else $error("zero denominator result carries a nonzero point");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(point_z)))
        else $error("stalled result lost or pipeline advanced");

endmodule

>>> sim/stri_checker.sv
`timescale 1ns / 100ps

module stri_checker
    import stri_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [PIX_W-1:0]        u_left,
    input  logic [PIX_W-1:0]        v_left,
    input  logic [PIX_W-1:0]        u_right,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [OUT_W-1:0] point_x,
    input  logic signed [OUT_W-1:0] point_y,
    input  logic signed [OUT_W-1:0] point_z,
    input  logic [1:0]              status,
    output int                      errors,
    output int                      pending
);

    localparam int DEPTH_SHIFT = 8;   // output fraction bits minus pixel fraction bits

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic [1:0]              st;
    } point_t;

    cfg_t   calib;
    point_t points_due[$];

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // truncated quotient of n * 2^s / d, clamped to the signed 32-bit range
    function automatic longint div_clamp(longint unsigned n, longint unsigned d, int s,
                                         bit neg, inout bit sat);
        longint unsigned lim;
        longint unsigned q;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q = (n << s) / d;
        if (q > lim)
        begin
            sat = 1'b1;
            q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic point_t triangulate(logic [PIX_W-1:0] ul, logic [PIX_W-1:0] vl,
                                           logic [PIX_W-1:0] ur);
        point_t p;
        longint du_l, dv_l, du_r, den, num, fu_l, fv_l, z;
        bit     sat;
        sat  = 1'b0;
        fu_l = longint'(calib.fu_l);
        fv_l = longint'(calib.fv_l);
        du_l = longint'(ul) - longint'(calib.cu_l);
        dv_l = longint'(vl) - longint'(calib.cv_l);
        du_r = longint'(ur) - longint'(calib.cu_r);
        den  = du_r * fu_l - du_l * longint'(calib.fu_r);
        num  = longint'(signed'(calib.tu_r)) * fu_l;
        if (den == 0 || fu_l == 0 || fv_l == 0)
        begin
            p.x = '0;
            p.y = '0;
            p.z = '0;
            p.st = STATUS_ZERO;
            return p;
        end
        z = div_clamp(mag(num), mag(den), DEPTH_SHIFT,
                      ((num < 0) != (den < 0)) && num != 0, sat);
        p.z = z[OUT_W-1:0];
        p.y = OUT_W'(div_clamp(mag(z) * mag(dv_l), fv_l, 0,
                               ((z < 0) != (dv_l < 0)) && z != 0 && dv_l != 0, sat));
        p.x = OUT_W'(div_clamp(mag(z) * mag(du_l), fu_l, 0,
                               ((z < 0) != (du_l < 0)) && z != 0 && du_l != 0, sat));
        p.st = sat ? STATUS_SAT : STATUS_OK;
        return p;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = points_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            calib.fu_l <= 20'd128000;
            calib.fv_l <= 20'd128000;
            calib.cu_l <= 20'd81920;
            calib.cv_l <= 20'd61440;
            calib.fu_r <= 20'd128000;
            calib.cu_r <= 20'd81920;
            calib.tu_r <= 32'hFF06_0000;
            points_due.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FU_L: calib.fu_l <= cfg_data[PIX_W-1:0];
                    CFG_FV_L: calib.fv_l <= cfg_data[PIX_W-1:0];
                    CFG_CU_L: calib.cu_l <= cfg_data[PIX_W-1:0];
                    CFG_CV_L: calib.cv_l <= cfg_data[PIX_W-1:0];
                    CFG_FU_R: calib.fu_r <= cfg_data[PIX_W-1:0];
                    CFG_CU_R: calib.cu_r <= cfg_data[PIX_W-1:0];
                    CFG_TU_R: calib.tu_r <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                points_due.push_back(triangulate(u_left, v_left, u_right));
            if (out_valid && !out_stall)
            begin
                if (points_due.size() == 0)
                    report("unexpected point", {point_x, point_y}, '0);
                else
                begin
                    want = points_due.pop_front();
                    if (point_x !== want.x)
                        report("point_x", point_x, want.x);
                    if (point_y !== want.y)
                        report("point_y", point_y, want.y);
                    if (point_z !== want.z)
                        report("point_z", point_z, want.z);
                    if (status !== want.st)
                        report("status", status, want.st);
                end
            end
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import stri_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int PIPE_LAT   = 72;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_ITEMS = 220;
    localparam logic [PIX_W-1:0] PIX_MAX = 20'hFFFFF;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [PIX_W-1:0]        u_left;
    logic [PIX_W-1:0]        v_left;
    logic [PIX_W-1:0]        u_right;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic signed [OUT_W-1:0] point_z;
    logic [1:0]              status;
    int                      errors;
    int                      pending;
    int                      items_sent;
    int                      idle_cycles;

    stereo_triangulation dut (.*);

    stri_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_obs(logic [PIX_W-1:0] ul, logic [PIX_W-1:0] vl,
                            logic [PIX_W-1:0] ur);
        int  gap;
        bit  taken;
        gap = ((items_sent / 64) % 4 == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        u_left   <= ul;
        v_left   <= vl;
        u_right  <= ur;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    // mostly plausible matches with a small disparity, the rest anything
    task automatic send_random_obs();
        logic [PIX_W-1:0] ul;
        ul = PIX_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            send_obs(ul, PIX_W'($urandom), PIX_W'($urandom));
        else
            send_obs(ul, PIX_W'($urandom), ul - PIX_W'($urandom_range(0, 40000)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int  wait_n;
        int  results;
        bit  held;
        bit  taken;
        results = 0;
        held = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results == 300)
            begin
                held = 1'b1;
                wait_n = 400;
            end
            else
                wait_n = ((results / 50) % 3 == 0) ? 0 : $urandom_range(0, 15);
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                taken = out_valid;
                @(posedge clk);
            end
            while (!taken);
            results++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
        items_sent = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        u_left    = '0;
        v_left    = '0;
        u_right   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default calibration: zero disparity, extremes, saturation
        send_obs('0, '0, '0);
        send_obs(PIX_MAX, PIX_MAX, PIX_MAX);
        send_obs(PIX_MAX, PIX_MAX, '0);
        send_obs('0, '0, PIX_MAX);
        send_obs('0, PIX_MAX, PIX_MAX);
        send_obs(PIX_MAX, '0, '0);
        send_obs(20'd81921, 20'd61440, 20'd81920);
        send_obs(20'd81920, 20'd61440, 20'd81921);
        send_obs(20'd81920, 20'd61440, 20'd71920);
        send_obs(20'd90000, 20'd70000, 20'd85000);
        send_obs(20'd70000, 20'd50000, 20'd60000);
        send_obs(20'd90000, 20'd50000, 20'd90000);
        repeat (PHASE_ITEMS) send_random_obs();
        drain();

        // zero translation, then ignored index
        cfg_write(CFG_TU_R, '0);
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        send_obs(20'd90000, 20'd70000, 20'd85000);
        send_obs(20'd81920, 20'd61440, 20'd81920);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    cfg_write(CFG_FU_L, 32'd1);
                    cfg_write(CFG_FV_L, 32'd1);
                    cfg_write(CFG_CU_L, '0);
                    cfg_write(CFG_CV_L, '0);
                    cfg_write(CFG_FU_R, 32'd1);
                    cfg_write(CFG_CU_R, '0);
                    cfg_write(CFG_TU_R, 32'h8000_0000);
                end
                1:
                begin
                    cfg_write(CFG_FU_L, 32'hFFFF_FFFF);
                    cfg_write(CFG_FV_L, 32'hFFFF_FFFF);
                    cfg_write(CFG_CU_L, 32'hFFFF_FFFF);
                    cfg_write(CFG_CV_L, 32'hFFFF_FFFF);
                    cfg_write(CFG_FU_R, 32'hFFFF_FFFF);
                    cfg_write(CFG_CU_R, 32'hFFFF_FFFF);
                    cfg_write(CFG_TU_R, 32'h7FFF_FFFF);
                end
                default:
                begin
                    cfg_write(CFG_FU_L, $urandom_range(1, PIX_MAX));
                    cfg_write(CFG_FV_L, $urandom_range(1, PIX_MAX));
                    cfg_write(CFG_CU_L, $urandom);
                    cfg_write(CFG_CV_L, $urandom);
                    cfg_write(CFG_FU_R, $urandom_range(1, PIX_MAX));
                    cfg_write(CFG_CU_R, $urandom);
                    cfg_write(CFG_TU_R, $urandom);
                end
            endcase
            send_obs('0, '0, '0);
            send_obs(PIX_MAX, PIX_MAX, PIX_MAX);
            send_obs(PIX_MAX, '0, '0);
            send_obs('0, PIX_MAX, PIX_MAX);
            repeat (PHASE_ITEMS) send_random_obs();
            in_valid <= 1'b0;
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
